// ===== rtl/psh_pkg.sv =====
// package for the point set hausdorff / chamfer block
// holds sizes, field widths and the controller state type; no dependencies
package psh_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_DIM    = 4;
  localparam int COORD_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int WORD_W  = MAX_DIM * COORD_BITS;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int RAD_W   = SUM_W + 16;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int DIST_W  = 25;
  localparam int TOT_W   = DIST_W + CNT_W;
  localparam int DVS_W   = CNT_W + 1;
  localparam int DIMS_W  = 3;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_METRIC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INNER,
    S_DRAIN,
    S_SQRT,
    S_NEXT,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== rtl/psh_if.sv =====
// valid/ready channel interfaces for point loads and results
// depends on psh_pkg
interface psh_in_if import psh_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic        [MODE_W-1:0]     mode;
  logic signed [COORD_BITS-1:0] coord_0;
  logic signed [COORD_BITS-1:0] coord_1;
  logic signed [COORD_BITS-1:0] coord_2;
  logic signed [COORD_BITS-1:0] coord_3;

  modport source (output valid, mode, coord_0, coord_1, coord_2, coord_3, input ready);
  modport sink   (input valid, mode, coord_0, coord_1, coord_2, coord_3, output ready);
endinterface

interface psh_out_if import psh_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              infinite;
  logic              points_dropped;

  modport source (output valid, distance, infinite, points_dropped, input ready);
  modport sink   (input valid, distance, infinite, points_dropped, output ready);
endinterface

// ===== rtl/psh_sqrt.sv =====
// iterative integer square root, one result bit per cycle
// depends on psh_pkg
module psh_sqrt import psh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int SCNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  val_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [SCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], val_r[RAD_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SCNT_W'(ROOT_W - 1);
        val_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        val_r  <= {val_r[RAD_W-3:0], 2'b00};
        rem_r  <= take ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], take};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/psh_div.sv =====
// restoring divider for the chamfer mean, one quotient bit per cycle
// depends on psh_pkg
module psh_div import psh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [TOT_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [TOT_W-1:0] quotient
);

  localparam int DCNT_W = $clog2(TOT_W + 1);

  logic [TOT_W-1:0]  q_r;
  logic [DVS_W-1:0]  d_r;
  logic [DVS_W:0]    rem_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    rem_sh;
  logic              take;

  // shift in the next dividend bit and subtract where it fits
  always_comb begin
    rem_sh = {rem_r[DVS_W-1:0], q_r[TOT_W-1]};
    take   = (rem_sh >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(TOT_W - 1);
        q_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= take ? (rem_sh - {1'b0, d_r}) : rem_sh;
        q_r   <= {q_r[TOT_W-2:0], take};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/point_set_hausdorff_chamfer.sv =====
// Point loads may follow back to back while the block is idle. A compute transaction
// is accepted in the idle state; then, per outer point of each pass, it streams the inner
// set from memory, takes a square root and passes a step state. Chamfer adds a divide, and
// the done state stages the result once the output register is free. The pair loop through
// the one-read-port point memories dominates the run time. Depends on psh_pkg and psh_if.
// Reset clears counts, overflow flag, config and control; point memories are not cleared.
module point_set_hausdorff_chamfer import psh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  psh_in_if.sink                in_ch,
  psh_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // point memories, one word of packed coordinates per point
  logic [WORD_W-1:0] mem_a [MAX_POINTS];
  logic [WORD_W-1:0] mem_b [MAX_POINTS];
  logic [WORD_W-1:0] rd_a_r, rd_b_r;

  state_t state_r, state_nxt;

  logic              metric_r;
  logic [DIMS_W-1:0] dims_r;
  logic [CNT_W-1:0]  a_cnt_r, b_cnt_r;
  logic              overflow_r;
  logic              pass_r;
  logic [IDX_W-1:0]  i_r, k_r;
  logic              v1_r, v2_r;
  logic [SQ_W-1:0]   sq_r [MAX_DIM];
  logic [SUM_W-1:0]  best_r;
  logic [DIST_W-1:0] maxd_r;
  logic [TOT_W-1:0]  total_r;
  logic              inf_r;
  logic [DIST_W-1:0] dist_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_inf_r;
  logic              out_drop_r;

  logic              acc;
  logic              load_a, load_b;
  logic [WORD_W-1:0] in_word;
  logic [IDX_W-1:0]  addr_a, addr_b;
  logic [WORD_W-1:0] outer_w, inner_w;
  logic [IDX_W-1:0]  outer_last, inner_last;
  logic [DIMS_W-1:0] dims_eff;
  logic [SUM_W-1:0]  sum;
  logic              sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0] sq_root;
  logic [TOT_W-1:0]  dv_quo;
  logic [DIST_W-1:0] near_d;
  logic              out_free;

  assign acc      = in_ch.valid && in_ch.ready;
  assign load_a   = acc && (in_ch.mode == MODE_LOAD_A) && !a_cnt_r[CNT_W-1];
  assign load_b   = acc && (in_ch.mode == MODE_LOAD_B) && !b_cnt_r[CNT_W-1];
  assign in_word  = {in_ch.coord_3, in_ch.coord_2, in_ch.coord_1, in_ch.coord_0};
  assign out_free = !out_valid_r || out_ch.ready;

  // outer set is read at i, inner set at k
  assign addr_a     = pass_r ? k_r : i_r;
  assign addr_b     = pass_r ? i_r : k_r;
  assign outer_w    = pass_r ? rd_b_r : rd_a_r;
  assign inner_w    = pass_r ? rd_a_r : rd_b_r;
  assign outer_last = IDX_W'((pass_r ? b_cnt_r : a_cnt_r) - 1'b1);
  assign inner_last = IDX_W'((pass_r ? a_cnt_r : b_cnt_r) - 1'b1);

  // clamp the dimension count to one through MAX_DIM
  always_comb begin
    if (dims_r == '0) dims_eff = DIMS_W'(1);
    else if (dims_r > DIMS_W'(MAX_DIM)) dims_eff = DIMS_W'(MAX_DIM);
    else dims_eff = dims_r;
  end

  // memory ports: write on load, registered read
  always_ff @(posedge clk) begin
    if (load_a) mem_a[a_cnt_r[IDX_W-1:0]] <= in_word;
    if (load_b) mem_b[b_cnt_r[IDX_W-1:0]] <= in_word;
    rd_a_r <= mem_a[addr_a];
    rd_b_r <= mem_b[addr_b];
  end

  // squared gap per lane, registered after the multiply
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_DIM; j++) begin
      logic signed [DIFF_W-1:0] df;
      logic [DIFF_W-1:0]        ad;
      df = DIFF_W'($signed(outer_w[j*COORD_BITS +: COORD_BITS]))
         - DIFF_W'($signed(inner_w[j*COORD_BITS +: COORD_BITS]));
      ad = df[DIFF_W-1] ? DIFF_W'(-df) : DIFF_W'(df);
      sq_r[j] <= (DIMS_W'(j) < dims_eff) ? SQ_W'(ad * ad) : '0;
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < MAX_DIM; j++) sum = sum + SUM_W'(sq_r[j]);
  end

  assign near_d = sq_root[DIST_W-1:0];

  psh_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({best_r, 16'd0}),
    .done     (sq_done),
    .root     (sq_root)
  );

  psh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (total_r),
    .divisor  (DVS_W'(a_cnt_r) + DVS_W'(b_cnt_r)),
    .done     (dv_done),
    .quotient (dv_quo)
  );

  // controller state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // next state and unit starts
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    sq_start    = 1'b0;
    dv_start    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (acc && in_ch.mode == MODE_COMPUTE) begin
          if (a_cnt_r == '0 || b_cnt_r == '0) state_nxt = S_DONE;
          else state_nxt = S_INNER;
        end
      end
      S_INNER: begin
        if (k_r == inner_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          sq_start  = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (i_r != outer_last || !pass_r) state_nxt = S_INNER;
        else if (metric_r) begin
          dv_start  = 1'b1;
          state_nxt = S_DIV;
        end else state_nxt = S_DONE;
      end
      S_DIV: begin
        if (dv_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and accumulation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r    <= 1'b0;
      dims_r      <= DIMS_W'(3);
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      overflow_r  <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
      inf_r       <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_METRIC) metric_r <= cfg_data[0];
      if (cfg_we && cfg_index == REG_DIMS) dims_r <= cfg_data;

      if (load_a) a_cnt_r <= a_cnt_r + 1'b1;
      if (load_b) b_cnt_r <= b_cnt_r + 1'b1;
      if (acc && (in_ch.mode == MODE_LOAD_A || in_ch.mode == MODE_LOAD_B)
          && !load_a && !load_b)
        overflow_r <= 1'b1;

      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      v1_r <= (state_r == S_INNER);
      v2_r <= v1_r;
      if (v2_r && sum < best_r) best_r <= sum;

      case (state_r)
        S_IDLE: begin
          if (acc && in_ch.mode == MODE_COMPUTE) begin
            inf_r   <= (a_cnt_r == '0 || b_cnt_r == '0);
            dist_r  <= '1;
            pass_r  <= 1'b0;
            i_r     <= '0;
            k_r     <= '0;
            best_r  <= '1;
            maxd_r  <= '0;
            total_r <= '0;
          end
        end
        S_INNER: k_r <= k_r + 1'b1;
        S_SQRT: begin
          if (sq_done) begin
            if (near_d > maxd_r) maxd_r <= near_d;
            total_r <= total_r + TOT_W'(near_d);
          end
        end
        S_NEXT: begin
          k_r    <= '0;
          best_r <= '1;
          if (i_r != outer_last) i_r <= i_r + 1'b1;
          else if (!pass_r) begin
            pass_r <= 1'b1;
            i_r    <= '0;
          end else if (!metric_r) dist_r <= maxd_r;
        end
        S_DIV: begin
          if (dv_done) dist_r <= dv_quo[DIST_W-1:0];
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_dist_r  <= dist_r;
            out_inf_r   <= inf_r;
            out_drop_r  <= overflow_r;
            a_cnt_r     <= '0;
            b_cnt_r     <= '0;
            overflow_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.distance       = out_dist_r;
  assign out_ch.infinite       = out_inf_r;
  assign out_ch.points_dropped = out_drop_r;

  // result transaction is staged on the cycle the done state finds the register free
  a_done_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> out_valid_r)
    else $error("result not staged after compute");

  // counts are cleared once a result is staged
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (a_cnt_r == '0 && b_cnt_r == '0 && !overflow_r))
    else $error("sets not cleared after compute");

  // counts never pass the store size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (a_cnt_r <= CNT_W'(MAX_POINTS)) && (b_cnt_r <= CNT_W'(MAX_POINTS)))
    else $error("point count beyond store size");

  // pair pipeline only runs while a compute is in progress
  a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (state_r == S_INNER || state_r == S_DRAIN))
    else $error("pair pipeline active outside compute");

endmodule
